// ===== rtl/maf_pkg.sv =====
// ============================================================================
// maf_pkg
// Shared constants for the moving average filter: default sizes, the
// configuration register map and the control state encoding.
// ============================================================================
package maf_pkg;

    // Default sizing of the window store and the sample path
    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // Configuration port
    localparam int CFG_DATA_BITS   = 32;
    localparam int CFG_ADDR_BITS   = 3;
    localparam int CFG_INDEX_LSB   = 2;

    // Register index (byte address / 4)
    localparam logic REG_WINDOW_SIZE = 1'b0;

    // window_size register
    localparam int               WINDOW_SIZE_BITS  = 7;
    localparam logic [6:0]       WINDOW_SIZE_RESET = 7'd4;

    // Control sequencer, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_UPD  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_HOLD = 4'b1000
    } maf_state_t;

endpackage

// ===== rtl/maf_ram.sv =====
// ============================================================================
// maf_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module maf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port (read-first on a clash)
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/moving_average_filter_unit.sv =====
// ============================================================================
// moving_average_filter_unit
// Simple moving average over a stream of signed samples.
// ============================================================================
// Usage
//   Samples arrive on the s_ channel (s_sample, s_first_of_sequence) and means
//   leave on the m_ channel (m_mean), both valid/ready. A sample with
//   s_first_of_sequence set empties the window before it is taken. Once the
//   window holds window_size samples (zero read as one, clipped to
//   WINDOW_MAX), every sample yields one mean (window sum divided by that
//   size, truncated toward zero); before that none. window_size is written
//   over the APB port at byte address 0; each write of it empties the window.
//   Write it only while the block is idle.
// Sequence
//   A sample that yields no mean passes through accept and window update.
//   A sample that yields a mean then passes through the bit-serial divider,
//   one quotient bit per cycle, and the output hold state. The next sample
//   is accepted while the mean waits in the output register.
// Reset
//   aresetn clears the window, sets window_size to 4 and drops any pending
//   mean. The window store itself is not cleared; it is only read where the
//   current sequence has written. A stalled receiver holds the sequencer with
//   the finished mean until the output register frees.
// ============================================================================
module moving_average_filter_unit #(
    parameter int WINDOW_MAX  = maf_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // sample input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample,
    input  logic                                s_first_of_sequence,
    // mean output
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [SAMPLE_BITS-1:0]       m_mean,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [maf_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [maf_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [maf_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                pready
);

    import maf_pkg::*;

    localparam int PTR_BITS  = $clog2(WINDOW_MAX);
    localparam int WCNT_BITS = $clog2(WINDOW_MAX + 1);
    localparam int OFS_BITS  = WCNT_BITS + 1;
    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW_MAX);
    localparam int CNT_BITS  = $clog2(SUM_BITS + 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    maf_state_t                    state_reg, state_next;
    logic [WINDOW_SIZE_BITS-1:0]   window_size_reg;
    logic [WCNT_BITS-1:0]          eff_w_reg;
    logic [SUM_BITS-1:0]           sum_reg;
    logic [WCNT_BITS-1:0]          fill_reg;
    logic [PTR_BITS-1:0]           wp_reg;
    logic                          emit_reg;
    logic                          fwd_reg;
    logic [SAMPLE_BITS-1:0]        fwd_data_reg;
    logic                          neg_reg;
    logic [SUM_BITS-1:0]           quo_reg;
    logic [WCNT_BITS-1:0]          rem_reg;
    logic [CNT_BITS-1:0]           cnt_reg;
    logic                          m_valid_reg;
    logic [SAMPLE_BITS-1:0]        m_mean_reg;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic s_xfer, m_xfer, cfg_wr, out_load;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_xfer   = s_valid & s_ready;
    assign m_xfer   = m_valid_reg & m_ready;
    assign out_load = (state_reg == ST_HOLD) & (~m_valid_reg | m_ready);
    assign cfg_wr   = psel & penable & pwrite & pready
                    & (paddr[CFG_INDEX_LSB] == REG_WINDOW_SIZE);

    assign pready  = 1'b1;
    assign prdata  = (paddr[CFG_INDEX_LSB] == REG_WINDOW_SIZE)
                   ? CFG_DATA_BITS'(window_size_reg) : '0;
    assign m_valid = m_valid_reg;
    assign m_mean  = m_mean_reg;

    // ------------------------------------------------------------------
    // Effective window for a register write: zero reads as 1, clipped
    // ------------------------------------------------------------------
    logic [WINDOW_SIZE_BITS-1:0] ws_wr;
    logic [31:0]                 eff32;

    assign ws_wr = pwdata[WINDOW_SIZE_BITS-1:0];

    always_comb begin
        if (ws_wr == '0) begin
            eff32 = 32'd1;
        end else if (32'(ws_wr) > 32'(WINDOW_MAX)) begin
            eff32 = 32'(WINDOW_MAX);
        end else begin
            eff32 = 32'(ws_wr);
        end
    end

    // ------------------------------------------------------------------
    // Accept path: window bookkeeping for the incoming sample
    // ------------------------------------------------------------------
    logic [PTR_BITS-1:0]  base_wp, wp_new, oldest;
    logic [SUM_BITS-1:0]  base_sum, sum_acc, s_ext;
    logic [WCNT_BITS-1:0] base_fill, fill_new;
    logic [OFS_BITS-1:0]  ofs;
    logic                 emit_now;

    always_comb begin
        base_wp   = s_first_of_sequence ? '0 : wp_reg;
        base_sum  = s_first_of_sequence ? '0 : sum_reg;
        base_fill = s_first_of_sequence ? '0 : fill_reg;
        s_ext     = {{(SUM_BITS-SAMPLE_BITS){s_sample[SAMPLE_BITS-1]}}, s_sample};
        sum_acc   = base_sum + s_ext;
        wp_new    = (32'(base_wp) == WINDOW_MAX - 1) ? '0 : base_wp + 1'b1;
        fill_new  = (base_fill < WCNT_BITS'(WINDOW_MAX)) ? base_fill + 1'b1 : base_fill;
        emit_now  = (fill_new >= eff_w_reg);
        // slot of the sample that leaves the window, modulo WINDOW_MAX
        ofs = OFS_BITS'(wp_new) + OFS_BITS'(WINDOW_MAX) - OFS_BITS'(eff_w_reg);
        if (ofs >= OFS_BITS'(WINDOW_MAX)) begin
            ofs = ofs - OFS_BITS'(WINDOW_MAX);
        end
        oldest = ofs[PTR_BITS-1:0];
    end

    // ------------------------------------------------------------------
    // Window store
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] ram_rdata;

    maf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_window_ram (
        .aclk  (aclk),
        .we    (s_xfer),
        .waddr (base_wp),
        .wdata (s_sample),
        .raddr (oldest),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Update cycle: drop the oldest sample, with forwarding of a sample
    // that was written in the same cycle as it was read
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] old_sample;
    logic [SUM_BITS-1:0]    old_ext, sum_abs;

    assign old_sample = fwd_reg ? fwd_data_reg : ram_rdata;
    assign old_ext    = {{(SUM_BITS-SAMPLE_BITS){old_sample[SAMPLE_BITS-1]}}, old_sample};
    assign sum_abs    = sum_reg[SUM_BITS-1] ? (~sum_reg + 1'b1) : sum_reg;

    // ------------------------------------------------------------------
    // Bit-serial restoring divider step
    // ------------------------------------------------------------------
    logic [WCNT_BITS:0]   rem_sh, rem_sub;
    logic                 q_bit;
    logic [SUM_BITS-1:0]  q_signed;

    always_comb begin
        rem_sh  = {rem_reg, quo_reg[SUM_BITS-1]};
        rem_sub = rem_sh - {1'b0, eff_w_reg};
        q_bit   = (rem_sh >= {1'b0, eff_w_reg});
    end

    assign q_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                state_next = emit_reg ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                if (cnt_reg == CNT_BITS'(1)) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            window_size_reg <= WINDOW_SIZE_RESET;
            eff_w_reg       <= WCNT_BITS'(WINDOW_SIZE_RESET > WINDOW_SIZE_BITS'(WINDOW_MAX)
                                          && WINDOW_MAX < 128 ? WINDOW_MAX : 4);
            sum_reg         <= '0;
            fill_reg        <= '0;
            wp_reg          <= '0;
            emit_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                window_size_reg <= ws_wr;
                eff_w_reg       <= WCNT_BITS'(eff32);
                sum_reg         <= '0;
                fill_reg        <= '0;
                wp_reg          <= '0;
            end else if (s_xfer) begin
                sum_reg  <= sum_acc;
                wp_reg   <= wp_new;
                fill_reg <= emit_now ? eff_w_reg - 1'b1 : fill_new;
                emit_reg <= emit_now;
            end else if (state_reg == ST_UPD && emit_reg) begin
                sum_reg <= sum_reg - old_ext;
            end
            // output register
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_xfer) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            fwd_reg      <= (oldest == base_wp);
            fwd_data_reg <= s_sample;
        end
        if (state_reg == ST_UPD) begin
            neg_reg <= sum_reg[SUM_BITS-1];
            quo_reg <= sum_abs;
            rem_reg <= '0;
            cnt_reg <= CNT_BITS'(SUM_BITS);
        end else if (state_reg == ST_DIV) begin
            quo_reg <= {quo_reg[SUM_BITS-2:0], q_bit};
            rem_reg <= q_bit ? rem_sub[WCNT_BITS-1:0] : rem_sh[WCNT_BITS-1:0];
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (out_load) begin
            m_mean_reg <= q_signed[SAMPLE_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_below_window: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg < eff_w_reg)
        else $error("fill count reached the window size");

    a_mean_from_divider: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_HOLD))
        else $error("mean presented without a finished division");

    a_no_mean_no_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) && !emit_reg |=> (state_reg == ST_IDLE))
        else $error("sample without a mean entered the divider");

endmodule

// ===== bench/moving_average_filter_unit_tb.sv =====
// ----------------------------------------------------------------------------
// moving_average_filter_unit_tb
// Self-checking bench for the moving average filter. Samples are driven over
// the s_ channel with random bursts and gaps, window_size is rewritten over
// the APB port between phases, and every mean on the m_ channel is compared
// in order with a running-sum window model held in the bench.
// ----------------------------------------------------------------------------
module moving_average_filter_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import maf_pkg::*;

    localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
    localparam int WINDOW_MAX  = WINDOW_MAX_DEF;
    localparam int PTR_BITS    = $clog2(WINDOW_MAX);
    localparam int SUM_BITS    = SAMPLE_BITS + PTR_BITS;

    // settle time: long enough to cover any item still in flight through the sequencer
    localparam int SETTLE_CYCLES   = 2 * (SAMPLE_BITS + PTR_BITS + 3);
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 4000;

    // ring of expected means, far deeper than the block can hold in flight
    localparam int EXPECT_BITS  = 4;
    localparam int EXPECT_DEPTH = 1 << EXPECT_BITS;

    localparam logic [CFG_ADDR_BITS-1:0] WINDOW_SIZE_ADDR =
        {{(CFG_ADDR_BITS-1){1'b0}}, REG_WINDOW_SIZE} << CFG_INDEX_LSB;

    typedef enum int {
        VAL_UNIFORM,
        VAL_EXTREME,
        VAL_SMALL,
        VAL_MIXED
    } value_mode_t;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic signed [SAMPLE_BITS-1:0]  s_sample;
    logic                           s_first_of_sequence;
    logic                           m_valid;
    logic                           m_ready;
    logic signed [SAMPLE_BITS-1:0]  m_mean;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [CFG_ADDR_BITS-1:0]       paddr;
    logic [CFG_DATA_BITS-1:0]       pwdata;
    logic [CFG_DATA_BITS-1:0]       prdata;
    logic                           pready;

    // window model
    logic signed [SAMPLE_BITS-1:0]  win_samples [WINDOW_MAX];
    logic signed [SUM_BITS-1:0]     win_sum;
    logic [WINDOW_SIZE_BITS-1:0]    win_count;
    logic [PTR_BITS-1:0]            win_wr_ptr;
    logic [WINDOW_SIZE_BITS-1:0]    win_size_reg;

    logic signed [SAMPLE_BITS-1:0]  expected_means [EXPECT_DEPTH];
    int                             expect_head = 0;
    int                             expect_tail = 0;

    int error_count       = 0;
    int burst_left        = 0;
    bit steady_sender     = 1'b0;
    int hold_off_requests = 0;
    int hold_off_served   = 0;

    moving_average_filter_unit i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_sample            (s_sample),
        .s_first_of_sequence (s_first_of_sequence),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_mean              (m_mean),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    always #1ns aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Window model
    // ------------------------------------------------------------------------

    // means queued but not yet seen on the m_ channel
    function automatic int means_outstanding();
        return expect_tail - expect_head;
    endfunction

    // zero counts as one, anything above the store depth saturates
    function automatic int window_span(input logic [WINDOW_SIZE_BITS-1:0] size);
        if (size == 0) begin
            return 1;
        end
        if (size > WINDOW_MAX) begin
            return WINDOW_MAX;
        end
        return int'(size);
    endfunction

    function automatic void empty_window();
        win_sum    = '0;
        win_count  = '0;
        win_wr_ptr = '0;
    endfunction

    // take one sample; queue a mean once the window is full
    function automatic void advance_window(input logic signed [SAMPLE_BITS-1:0] smp,
                                           input logic first);
        int                         span;
        int                         oldest;
        logic signed [SUM_BITS-1:0] quotient;
        span = window_span(win_size_reg);
        if (first) begin
            empty_window();
        end
        win_samples[win_wr_ptr] = smp;
        win_wr_ptr = win_wr_ptr + 1'b1;
        win_sum = win_sum + smp;
        if (win_count < WINDOW_MAX) begin
            win_count = win_count + 1'b1;
        end
        if (int'(win_count) >= span) begin
            quotient = SUM_BITS'(win_sum / span);
            expected_means[EXPECT_BITS'(expect_tail)] = quotient[SAMPLE_BITS-1:0];
            expect_tail++;
            oldest = (int'(win_wr_ptr) + WINDOW_MAX - span) % WINDOW_MAX;
            win_sum = win_sum - win_samples[PTR_BITS'(oldest)];
            win_count = WINDOW_SIZE_BITS'(span - 1);
        end
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input value_mode_t mode);
        case (mode)
            VAL_EXTREME: begin
                return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            end
            VAL_SMALL: begin
                // small values around zero bring out truncation of negative sums
                return SAMPLE_BITS'($urandom_range(0, 16)) - 16'sd8;
            end
            VAL_MIXED: begin
                case ($urandom_range(0, 4))
                    0: return 16'sh7fff;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    3: return 16'shffff;
                    default: return SAMPLE_BITS'($urandom);
                endcase
            end
            default: begin
                return SAMPLE_BITS'($urandom);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------

    // offer one sample and hold it until the transfer; gaps fall between bursts
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp,
                               input logic first);
        int gap;
        if (!steady_sender && burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                if (s_valid) begin
                    s_valid <= 1'b0;
                end
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid             <= 1'b1;
        s_sample            <= smp;
        s_first_of_sequence <= first;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        advance_window(smp, first);
        if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    // stop offering and let every mean and any silent update finish
    task automatic wait_until_idle();
        if (s_valid) begin
            s_valid <= 1'b0;
        end
        while (means_outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_window_size(input logic [CFG_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WINDOW_SIZE_ADDR;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        win_size_reg = value[WINDOW_SIZE_BITS-1:0];
        empty_window();
    endtask

    // mostly well-formed sequences long enough to fill the window
    task automatic run_sample_stream(input int n_items);
        int          span;
        int          sent;
        int          seq_len;
        int          k;
        logic        first;
        value_mode_t mode;
        span = window_span(win_size_reg);
        sent = 0;
        while (sent < n_items) begin
            mode = value_mode_t'($urandom_range(0, 3));
            if ($urandom_range(0, 7) == 0) begin
                seq_len = $urandom_range(1, span);
            end else begin
                seq_len = span + $urandom_range(0, 2 * span + 8);
            end
            for (k = 0; k < seq_len && sent < n_items; k++) begin
                if (k == 0) begin
                    first = ($urandom_range(0, 9) != 0);
                end else begin
                    first = ($urandom_range(0, 39) == 0);
                end
                send_sample(pick_sample(mode), first);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // window of 4 from reset: full-scale sums, truncation, restarts
    task automatic test_default_window_extremes();
        // restart on an empty window, full-scale positive then negative
        send_sample(16'sh7fff, 1'b1);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        // restart on a full window; small negative sums round toward zero
        send_sample(-16'sd1, 1'b1);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd3, 1'b0);
        send_sample(-16'sd5, 1'b0);
        // restart on a partly filled window
        send_sample(16'sd5, 1'b1);
        send_sample(16'sd6, 1'b1);
        send_sample(16'sd7, 1'b0);
        send_sample(16'sd9, 1'b0);
        send_sample(-16'sd1, 1'b0);
        wait_until_idle();
    endtask

    // a size of zero behaves as one: every sample comes straight back
    task automatic test_unit_window();
        write_window_size('0);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sd1, 1'b1);
        send_sample(-16'sd1, 1'b0);
        wait_until_idle();
    endtask

    // sizes from zero to the store depth, saturation, and a fully random word
    task automatic test_window_sweep();
        int sizes [10] = '{1, 2, 3, 7, 16, 40, 64, 127, 0, 5};
        int i;
        logic [CFG_DATA_BITS-1:0] value;
        for (i = 0; i < 10; i++) begin
            if (i == 9) begin
                value = $urandom;
            end else begin
                value = CFG_DATA_BITS'(sizes[i]);
            end
            write_window_size(value);
            run_sample_stream((3 * window_span(value[WINDOW_SIZE_BITS-1:0]) > 50) ?
                              3 * window_span(value[WINDOW_SIZE_BITS-1:0]) : 50);
            wait_until_idle();
        end
    endtask

    // receiver holds off while samples keep coming, so the input backs up
    task automatic test_output_backpressure();
        int k;
        write_window_size(CFG_DATA_BITS'(1));
        steady_sender = 1'b1;
        hold_off_requests++;
        for (k = 0; k < 120; k++) begin
            send_sample(pick_sample(VAL_MIXED), (k == 0));
        end
        steady_sender = 1'b0;
        wait_until_idle();
    endtask

    // ------------------------------------------------------------------------
    // Mean receiver: stall pattern changes at random, with forced hold-off cycles
    // ------------------------------------------------------------------------
    initial begin : mean_receiver
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        int       cycle_no;
        m_ready <= 1'b0;
        mode      = RX_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        cycle_no  = 0;
        forever begin
            @(posedge aclk);
            cycle_no++;
            if (hold_off_served != hold_off_requests) begin
                hold_left = HOLD_OFF_CYCLES;
                hold_off_served++;
            end
            if (mode_left == 0) begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    RX_RANDOM:   m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   m_ready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: m_ready <= ((cycle_no % 5) < 2);
                    default:     m_ready <= 1'b1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Mean checker: each transfer against the oldest expected mean
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : mean_checker
        logic signed [SAMPLE_BITS-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (means_outstanding() == 0) begin
                $display("%0t: unexpected mean, expected none, actual %0d", $time, m_mean);
                error_count++;
            end else begin
                want = expected_means[EXPECT_BITS'(expect_head)];
                expect_head++;
                if (m_mean !== want) begin
                    $display("%0t: mean mismatch, expected %0d, actual %0d",
                             $time, want, m_mean);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles without any transfer
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t: no transfer for %0d cycles, %0d means outstanding",
                 $time, WATCHDOG_LIMIT, means_outstanding());
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        aresetn             <= 1'b0;
        s_valid             <= 1'b0;
        s_sample            <= '0;
        s_first_of_sequence <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        win_size_reg = WINDOW_SIZE_RESET;
        empty_window();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_default_window_extremes();
        test_unit_window();
        test_window_sweep();
        test_output_backpressure();
        wait_until_idle();

        if (means_outstanding() != 0) begin
            $display("%0t: %0d expected means never arrived", $time, means_outstanding());
            error_count++;
        end
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
